[rtl/ssd_pkg.sv]
// Shared types, codes and segment table for the seven-segment scan display.
package ssd_pkg;

   // Default number of decimal digit positions
   localparam int DEFAULT_DIGIT_COUNT = 6;

   // Width of the binary number taken by a load-number transaction
   localparam int VALUE_WIDTH = 32;

   // Function codes of a request transaction
   localparam logic [1:0] FUNC_SCAN     = 2'd0;
   localparam logic [1:0] FUNC_LOAD_NUM = 2'd1;
   localparam logic [1:0] FUNC_LOAD_LED = 2'd2;

   // Active-low segment byte that leaves a position dark
   localparam logic [7:0] SEG_BLANK = 8'hFF;

   typedef struct packed {
      logic [1:0]             func;
      logic [VALUE_WIDTH-1:0] number_value;
      logic [7:0]             led_pattern;
   } req_type;

   typedef struct packed {
      logic [2:0] position_select;
      logic [7:0] segment_byte;
   } rsp_type;

   // Converter status seen by the top level
   typedef struct packed {
      logic busy;
      logic done;
   } conv_status_type;

   // Map one BCD digit to its active-low segment byte
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

endpackage

[rtl/ssd_bcd_conv.sv]
// Iterative shift-and-add-3 binary to BCD converter, one input bit per cycle.
module ssd_bcd_conv #(
   parameter int DIGIT_COUNT = ssd_pkg::DEFAULT_DIGIT_COUNT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 conv_start,
   input  logic [ssd_pkg::VALUE_WIDTH-1:0]      conv_value,
   output ssd_pkg::conv_status_type             conv_status,
   output logic [4*DIGIT_COUNT-1:0]             conv_bcd
);
   import ssd_pkg::*;

   localparam int BCD_WIDTH = 4 * DIGIT_COUNT;
   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(VALUE_WIDTH - 1);

   // Sequencer state codes
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                   state_ff, state_in;
   logic                   done_ff, done_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]   bcd_adj;

   // Add 3 to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Sequence: load, then shift one bit per cycle, then flag done
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (conv_start) begin
               state_in = ST_RUN;
               count_in = '0;
               shift_in = conv_value;
               bcd_in   = '0;
            end
         end
         ST_RUN: begin
            bcd_in   = {bcd_adj[BCD_WIDTH-2:0], shift_ff[VALUE_WIDTH-1]};
            shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = ST_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign conv_status.busy = (state_ff == ST_RUN) || done_ff;
   assign conv_status.done = done_ff;
   assign conv_bcd         = bcd_ff;

endmodule

[rtl/seven_segment_scan_display.sv]
// Top level of the multiplexed seven-segment scan display driver.
//
// Request channel: a transaction is taken at a rising edge with start high
// and busy low. req_data.func selects a scan tick, a load-number or a
// load-LED transaction.
// Scan tick: the position byte appears on rsp_data in the cycle
// after acceptance, marked by rsp_valid for exactly one cycle, and the
// scan position advances, wrapping after the LED bank position.
// Load number: the converter takes one input bit per cycle, then the
// digit bytes are written from its result. busy is high meanwhile.
// Load LED: the inverted pattern lands in the LED bank entry.
// Loads produce no response. Unused function codes are dropped.
// Responses cannot be held off; each is valid for one cycle only.
// Reset blanks every position (0xFF), zeroes the scan position and
// leaves the block idle at once.
module seven_segment_scan_display #(
   parameter int DIGIT_COUNT = ssd_pkg::DEFAULT_DIGIT_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ssd_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output ssd_pkg::rsp_type rsp_data
);
   import ssd_pkg::*;

   localparam int POSITIONS = DIGIT_COUNT + 1;
   localparam int PW        = $clog2(POSITIONS);
   localparam logic [PW-1:0] LAST_POS = PW'(DIGIT_COUNT);

   conv_status_type          conv_status;
   logic [4*DIGIT_COUNT-1:0] conv_bcd;
   logic                     accept;
   logic                     scan_go;
   logic                     conv_go;

   logic [7:0]    store_ff [POSITIONS];
   logic [PW-1:0] pos_ff, pos_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   logic [PW+2:0] pos_ext;

   assign busy    = conv_status.busy;
   assign accept  = start && !busy;
   assign scan_go = accept && (req_data.func == FUNC_SCAN);
   assign conv_go = accept && (req_data.func == FUNC_LOAD_NUM);

   ssd_bcd_conv #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_conv (
      .clock       (clock),
      .reset       (reset),
      .conv_start  (conv_go),
      .conv_value  (req_data.number_value),
      .conv_status (conv_status),
      .conv_bcd    (conv_bcd)
   );

   // Advance the scan position, wrap after the LED bank
   always_comb begin
      pos_in = pos_ff;
      if (scan_go) begin
         if (pos_ff >= LAST_POS) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign pos_ext = (PW+3)'(pos_ff);

   // Segment store: digits from the converter, LED bank from load-LED
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POSITIONS; i++) begin
            store_ff[i] <= SEG_BLANK;
         end
      end else begin
         if (conv_status.done) begin
            for (int k = 0; k < DIGIT_COUNT; k++) begin
               store_ff[k] <= seg_code(conv_bcd[4*(DIGIT_COUNT-1-k) +: 4]);
            end
         end
         if (accept && (req_data.func == FUNC_LOAD_LED)) begin
            store_ff[DIGIT_COUNT] <= ~req_data.led_pattern;
         end
      end
   end

   // Hold scan position and register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= scan_go;
      end
      if (scan_go) begin
         rsp_data_ff.position_select <= pos_ext[2:0];
         rsp_data_ff.segment_byte    <= store_ff[pos_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A response only follows an accepted scan tick
   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && (req_data.func == FUNC_SCAN)))
      else $error("response without a scan tick");

   // A load-number transaction makes the block busy on the next cycle
   a_conv_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.func == FUNC_LOAD_NUM)) |=> busy)
      else $error("load number did not raise busy");

   // The scan position stays within the LED bank position
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("scan position out of range");

   // Nothing is accepted while the converter result is pending
   a_no_accept_done: assert property (@(posedge clock) disable iff (reset)
      conv_status.done |-> busy)
      else $error("converter done while idle");

endmodule
